@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker of the power rail sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/prs_pkg.sv @@
// Types and constants of the power rail sequencer.
package prs_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned RailN    = 3;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  localparam int unsigned RailLow  = 0;
  localparam int unsigned RailMid  = 1;
  localparam int unsigned RailHigh = 2;

  // Result item, low_rail_on in bit 0.
  typedef struct packed {
    logic             settling;
    logic [RailN-1:0] changed_mask;
    logic             high_rail_on;
    logic             mid_rail_on;
    logic             low_rail_on;
  } result_t;

endpackage

@@ rtl/core/power_rail_sequencer.sv @@
// Power rail sequencer: tick items in, one registered result item per tick out.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | want_mid_rail, want_high_rail, now_time_ms
//  m_axis   | out       | rail enables, changed_mask, settling
//  cfg      | in        | step_delay_ms
//
// One tick per clock while s_axis_tready is high; the result is registered in the output slot.
// The rail update is one subtract and compare on the registered state.
// rst (synchronous) clears the rails, the started flag, the delay and both
// output slots. A stalled m_axis side fills the skid slot, after which
// s_axis_tready drops until the output slot drains.
module power_rail_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] want_mid_rail, [1] want_high_rail, [33:2] now_time_ms, [39:34] zero
  input  logic [prs_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] low_rail_on, [1] mid_rail_on, [2] high_rail_on, [5:3] changed_mask,
  // [6] settling, [7] zero
  output logic [prs_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [prs_pkg::DelayW-1:0]    cfg_wdata
);

  logic [prs_pkg::DelayW-1:0] step_delay_ms;
  logic                       sequence_started;
  logic [prs_pkg::TimeW-1:0]  last_step_time;
  logic [prs_pkg::RailN-1:0]  rail_enables;

  logic                       want_mid;
  logic                       want_high;
  logic [prs_pkg::TimeW-1:0]  now_time;
  logic [prs_pkg::TimeW-1:0]  elapsed;
  logic                       delay_ok;
  logic [prs_pkg::RailN-1:0]  rails_off;
  logic [prs_pkg::RailN-1:0]  rail_enables_next;
  logic                       step;
  prs_pkg::result_t           result;

  prs_pkg::result_t           out_data;
  logic                       out_valid;
  prs_pkg::result_t           skid_data;
  logic                       skid_valid;
  logic                       accept;
  logic                       pop;

  assign want_mid  = s_axis_tdata[0];
  assign want_high = s_axis_tdata[1];
  assign now_time  = s_axis_tdata[prs_pkg::TimeW+1:2];

  // Wrapping difference since the last power-up step.
  assign elapsed  = now_time - last_step_time;
  assign delay_ok = elapsed >= {{(prs_pkg::TimeW-prs_pkg::DelayW){1'b0}}, step_delay_ms};

  always_comb begin
    rails_off = rail_enables;
    if (!want_high) rails_off[prs_pkg::RailHigh] = 1'b0;
    if (!want_mid)  rails_off[prs_pkg::RailMid]  = 1'b0;

    rail_enables_next = rails_off;
    step              = 1'b0;
    if (!sequence_started || !rails_off[prs_pkg::RailLow]) begin
      rail_enables_next[prs_pkg::RailLow] = 1'b1;
      step = 1'b1;
    end else if (delay_ok && want_mid && !rails_off[prs_pkg::RailMid]) begin
      rail_enables_next[prs_pkg::RailMid] = 1'b1;
      step = 1'b1;
    end else if (delay_ok && want_high && !rails_off[prs_pkg::RailHigh]) begin
      rail_enables_next[prs_pkg::RailHigh] = 1'b1;
      step = 1'b1;
    end

    result.low_rail_on  = rail_enables_next[prs_pkg::RailLow];
    result.mid_rail_on  = rail_enables_next[prs_pkg::RailMid];
    result.high_rail_on = rail_enables_next[prs_pkg::RailHigh];
    result.changed_mask = rail_enables ^ rail_enables_next;
    result.settling     = !rail_enables_next[prs_pkg::RailLow]
                       || (want_mid  && !rail_enables_next[prs_pkg::RailMid])
                       || (want_high && !rail_enables_next[prs_pkg::RailHigh]);
  end

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay_ms    <= '0;
      sequence_started <= 1'b0;
      last_step_time   <= '0;
      rail_enables     <= '0;
    end else begin
      if (cfg_we) step_delay_ms <= cfg_wdata;
      if (accept) begin
        sequence_started <= 1'b1;
        rail_enables     <= rail_enables_next;
        if (step) last_step_time <= now_time;
      end
    end
  end

  // Output slot plus skid slot; results leave in acceptance order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= accept;
        if (accept) skid_data <= result;
      end else begin
        out_valid <= accept;
        if (accept) out_data <= result;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
      skid_data  <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(prs_pkg::OutDataW-$bits(prs_pkg::result_t)){1'b0}}, out_data};

endmodule

@@ rtl/core/prs_checker.sv @@
// Port-level checker for the power rail sequencer, bound to the top level.
`include "assert_macros.svh"

module prs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [prs_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic [prs_pkg::RailN-1:0] rails_on;
  logic [prs_pkg::RailN-1:0] rails_changed;

  assign rails_on      = m_axis_tdata[2:0];
  assign rails_changed = m_axis_tdata[5:3];

  // Hold a stalled result transaction.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

  // The low rail is on in every result.
  `ASSERT_SAME(a_low_on, clk, rst, m_axis_tvalid, rails_on[prs_pkg::RailLow])

  // At most one rail comes up per tick.
  `ASSERT_SAME(a_one_step, clk, rst, m_axis_tvalid,
    $countones(rails_on & rails_changed) <= 1)

  // A transaction taken while the output is stalled fills the skid slot.
  `ASSERT_NEXT(a_skid_fill, clk, rst,
    m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready,
    !s_axis_tready)

endmodule

bind power_rail_sequencer prs_checker u_prs_checker (.*);

@@ tb/sv/power_rail_sequencer_checker.sv @@
// Checker for the power rail sequencer: tracks the rail state and checks every result transaction.
module power_rail_sequencer_checker
  import prs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we,
  input  logic [DelayW-1:0]   cfg_wdata,
  output int                  errors,
  output int                  pending
);

  logic [DelayW-1:0] step_delay = '0;
  logic              started = 1'b0;
  logic [TimeW-1:0]  step_stamp = '0;
  logic [RailN-1:0]  rails = '0;
  result_t           expected_rails[$];
  int                mismatches = 0;

  assign errors = mismatches;

  // Advance the rail state by one tick and return the result it yields.
  function automatic result_t sequence_rails(input logic want_mid, input logic want_high,
                                             input logic [TimeW-1:0] now_ms);
    logic [RailN-1:0] prior;
    logic [TimeW-1:0] elapsed;
    result_t          r;
    prior = rails;
    // Drop unwanted rails first, high before mid; low always stays up
    if (!want_high) rails[RailHigh] = 1'b0;
    if (!want_mid) rails[RailMid] = 1'b0;
    elapsed = now_ms - step_stamp;
    if (!started || !rails[RailLow]) begin
      started = 1'b1;
      step_stamp = now_ms;
      rails[RailLow] = 1'b1;
    end else if (elapsed >= {{(TimeW-DelayW){1'b0}}, step_delay}) begin
      if (want_mid && !rails[RailMid]) begin
        step_stamp = now_ms;
        rails[RailMid] = 1'b1;
      end else if (want_high && !rails[RailHigh]) begin
        step_stamp = now_ms;
        rails[RailHigh] = 1'b1;
      end
    end
    r.low_rail_on  = rails[RailLow];
    r.mid_rail_on  = rails[RailMid];
    r.high_rail_on = rails[RailHigh];
    r.changed_mask = prior ^ rails;
    r.settling     = !rails[RailLow] || (want_mid && !rails[RailMid]) ||
                     (want_high && !rails[RailHigh]);
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      step_delay = '0;
      started = 1'b0;
      step_stamp = '0;
      rails = '0;
      expected_rails.delete();
    end else begin
      if (cfg_we) step_delay = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        expected_rails.push_back(sequence_rails(s_axis_tdata[0], s_axis_tdata[1],
                                                s_axis_tdata[TimeW+1:2]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rails.size() == 0) begin
          $display("%0t: result expected none, got %0h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_rails.pop_front();
          got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
          check_field("low_rail_on", 8'(want.low_rail_on), 8'(got.low_rail_on));
          check_field("mid_rail_on", 8'(want.mid_rail_on), 8'(got.mid_rail_on));
          check_field("high_rail_on", 8'(want.high_rail_on), 8'(got.high_rail_on));
          check_field("changed_mask", 8'(want.changed_mask), 8'(got.changed_mask));
          check_field("settling", 8'(want.settling), 8'(got.settling));
          check_field("tdata padding", '0, 8'(m_axis_tdata[OutDataW-1:$bits(result_t)]));
        end
      end
    end
    pending <= expected_rails.size();
  end

endmodule

@@ tb/sv/tb_power_rail_sequencer.sv @@
// Testbench top for the power rail sequencer: clock, reset, tick stimulus and verdict.
module tb_power_rail_sequencer;
  import prs_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we = 1'b0;
  logic [DelayW-1:0]   cfg_wdata = '0;
  int                  errors;
  int                  pending;
  int unsigned         idle_pct = 0;
  int unsigned         stall_pct = 0;

  power_rail_sequencer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  power_rail_sequencer_checker rail_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .pending       (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_tick(input bit want_mid, input bit want_high,
                           input logic [TimeW-1:0] now_ms);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW-TimeW-2){1'b0}}, now_ms, want_high, want_mid};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Hold off the sender until every outstanding result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_delay(input logic [DelayW-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly steady wanted states with timestamps stepping around the delay; some noise.
  task automatic run_ticks(input int count, input logic [DelayW-1:0] delay);
    logic [TimeW-1:0] clock_ms;
    logic [TimeW-1:0] step;
    bit               mid_goal;
    bit               high_goal;
    int               run_left;
    clock_ms = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(200000) : $urandom();
    run_left = 0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      if (run_left == 0) begin
        mid_goal = 1'($urandom_range(1));
        high_goal = 1'($urandom_range(1));
        run_left = $urandom_range(1, 20);
      end
      run_left--;
      if ($urandom_range(9) == 0) begin
        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
      end else begin
        case ($urandom_range(5))
          0: step = '0;
          1: step = $urandom_range(delay);
          2: step = delay - 32'd1;
          3: step = delay;
          4: step = delay + 32'd1;
          default: step = $urandom_range(2 * delay + 3);
        endcase
        clock_ms += step;
        send_tick(mid_goal, high_goal, clock_ms);
      end
    end
  endtask

  initial begin : limit
    #4_000_000;
    $display("power_rail_sequencer test failed");
    $finish;
  end

  initial begin : stimulus
    logic [DelayW-1:0] phase_delay;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_delay(16'd3);
    // First tick brings up low only; timestamps wrap through zero
    send_tick(1'b1, 1'b1, 32'hFFFF_FFFE);
    send_tick(1'b1, 1'b1, 32'hFFFF_FFFF);
    send_tick(1'b1, 1'b1, 32'h0000_0001);
    send_tick(1'b1, 1'b1, 32'h0000_0002);
    send_tick(1'b1, 1'b1, 32'h0000_0004);
    send_tick(1'b0, 1'b1, 32'h0000_0005);
    send_tick(1'b0, 1'b0, 32'h0000_0006);
    // High alone does not wait for an unwanted mid
    send_tick(1'b0, 1'b1, 32'h0000_0006);
    send_tick(1'b0, 1'b1, 32'h0000_0007);
    send_tick(1'b1, 1'b1, 32'hFFFF_FFFF);
    send_tick(1'b1, 1'b0, 32'h8000_0000);
    send_tick(1'b0, 1'b0, 32'hAAAA_AAAA);
    send_tick(1'b1, 1'b1, 32'h5555_5555);
    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      case (phase)
        0: phase_delay = 16'd0;
        1: phase_delay = 16'hFFFF;
        2: phase_delay = 16'd1;
        3: phase_delay = 16'd5;
        4: phase_delay = 16'd40;
        5: phase_delay = 16'($urandom_range(16'hFFFF));
        6: phase_delay = 16'hFFFE;
        default: phase_delay = 16'd2;
      endcase
      write_delay(phase_delay);
      case (phase % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 77;
        end
        default: begin
          idle_pct = 13;
          stall_pct = 13;
        end
      endcase
      run_ticks(236, phase_delay);
    end
    drain_results();
    if (errors == 0) begin
      $display("power_rail_sequencer test passed");
    end else begin
      $display("power_rail_sequencer test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/prs_pkg.sv
rtl/core/power_rail_sequencer.sv
rtl/core/prs_checker.sv
tb/sv/power_rail_sequencer_checker.sv
tb/sv/tb_power_rail_sequencer.sv
